/* sv/cpuet_pkg.sv */
// package: types, constants and priority table of the cpu exception and timer unit
package cpuet_pkg;

  localparam int unsigned CodeW  = 6;
  localparam int unsigned PrioW  = 5;
  localparam int unsigned RandW  = 5;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CodeW-1:0] CODE_NONE = 6'd35;
  localparam logic [CodeW-1:0] CODE_COLD = 6'd32;
  localparam logic [CodeW-1:0] CODE_SOFT = 6'd33;
  localparam logic [CodeW-1:0] CODE_NMI  = 6'd34;
  localparam logic [CodeW-1:0] CODE_TLBL = 6'd2;
  localparam logic [CodeW-1:0] CODE_TLBS = 6'd3;

  localparam logic [WordW-1:0] VEC_RESET     = 32'hBFC0_0000;
  localparam logic [WordW-1:0] VEC_TLB_BOOT  = 32'hBFC0_0200;
  localparam logic [WordW-1:0] VEC_TLB_NORM  = 32'h8000_0000;
  localparam logic [WordW-1:0] VEC_GEN_BOOT  = 32'hBFC0_0380;
  localparam logic [WordW-1:0] VEC_GEN_NORM  = 32'h8000_0180;
  localparam logic [WordW-1:0] PC_STEP       = 32'd4;
  localparam logic [RandW-1:0] RAND_TOP      = 5'd31;

  localparam logic [CfgIdxW-1:0] CFG_TIMER_COMPARE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIRED_LIMIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOOT_VECTORS  = 2'd2;

  typedef enum logic {
    OP_RAISE = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RK_NONE = 2'd0,
    RK_COLD = 2'd1,
    RK_SOFT = 2'd2,
    RK_NMI  = 2'd3
  } reset_kind_e;

  typedef struct packed {
    logic [WordW-1:0] timer_compare;
    logic [RandW-1:0] wired_limit;
    logic             boot_vectors;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{timer_compare: '0, wired_limit: '0, boot_vectors: 1'b1};

  typedef struct packed {
    logic [CodeW-1:0] pending;
    logic [WordW-1:0] count;
    logic [RandW-1:0] random;
    logic             timer;
    logic             exl;
    logic [4:0]       cause;
    logic             bd;
    logic [WordW-1:0] epc;
    logic [WordW-1:0] error_epc;
  } state_t;

  localparam state_t STATE_RESET = '{
    pending: CODE_NONE, count: '0, random: RAND_TOP, timer: 1'b0, exl: 1'b0,
    cause: '0, bd: 1'b0, epc: '0, error_epc: '0
  };

  typedef struct packed {
    logic             redirect;
    logic [WordW-1:0] target_pc;
    logic [CodeW-1:0] taken_code;
    logic [WordW-1:0] saved_pc;
    logic             branch_delay_flag;
    logic             exception_level;
    logic [WordW-1:0] count_value;
    logic [RandW-1:0] random_value;
    logic             timer_pending;
    reset_kind_e      reset_kind;
  } result_t;

  function automatic logic [PrioW-1:0] prio_of(input logic [CodeW-1:0] code);
    logic [PrioW-1:0] p;
    case (code)
      6'd0:    p = 5'd1;
      6'd1:    p = 5'd4;
      6'd2:    p = 5'd5;
      6'd3:    p = 5'd15;
      6'd4:    p = 5'd6;
      6'd5:    p = 5'd16;
      6'd6:    p = 5'd14;
      6'd7:    p = 5'd2;
      6'd8:    p = 5'd13;
      6'd9:    p = 5'd12;
      6'd10:   p = 5'd10;
      6'd11:   p = 5'd11;
      6'd12:   p = 5'd8;
      6'd13:   p = 5'd9;
      6'd15:   p = 5'd7;
      6'd23:   p = 5'd3;
      6'd32:   p = 5'd19;
      6'd33:   p = 5'd18;
      6'd34:   p = 5'd17;
      default: p = 5'd0;
    endcase
    return p;
  endfunction

endpackage

/* sv/cpuet_ifs.sv */
// channel interfaces: input items, results and configuration writes
interface cpuet_in_if;
  import cpuet_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [CodeW-1:0] exc_code;
  logic [WordW-1:0] current_pc;
  logic             delay_slot;
  logic             cpu_active;
  modport source (output valid, operation, exc_code, current_pc, delay_slot, cpu_active,
                  input ready);
  modport sink (input valid, operation, exc_code, current_pc, delay_slot, cpu_active,
                output ready);
endinterface

interface cpuet_res_if;
  import cpuet_pkg::*;
  logic             valid;
  logic             ready;
  logic             redirect;
  logic [WordW-1:0] target_pc;
  logic [CodeW-1:0] taken_code;
  logic [WordW-1:0] saved_pc;
  logic             branch_delay_flag;
  logic             exception_level;
  logic [WordW-1:0] count_value;
  logic [RandW-1:0] random_value;
  logic             timer_pending;
  logic [1:0]       reset_kind;
  modport source (output valid, redirect, target_pc, taken_code, saved_pc, branch_delay_flag,
                  exception_level, count_value, random_value, timer_pending, reset_kind,
                  input ready);
  modport sink (input valid, redirect, target_pc, taken_code, saved_pc, branch_delay_flag,
                exception_level, count_value, random_value, timer_pending, reset_kind,
                output ready);
endinterface

interface cpuet_cfg_if;
  import cpuet_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/cpu_exception_and_timer_unit.sv */
// top level: exception priority latch, count/compare timer and random index
//
//   channel | dir | handshake            | payload
//   in_i    | in  | valid/ready          | operation, exc_code, current_pc, delay_slot, cpu_active
//   res_o   | out | valid/ready          | redirect .. reset_kind, one per input transaction
//   cfg_i   | in  | valid/ready (ready=1)| index, data
//
// one item per cycle unless stalled; each result appears the cycle after its input is taken
// state is updated in the accepting cycle, so consecutive transactions see each other at once
// the result register frees in the same cycle it is read, so in_i.ready stays high under flow
// in_i.ready drops only while a result is held and res_o.ready is low
// reset puts all state and configuration at cold-reset values, pending code none
module cpu_exception_and_timer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpuet_in_if.sink    in_i,
  cpuet_res_if.source res_o,
  cpuet_cfg_if.sink   cfg_i
);
  import cpuet_pkg::*;

  state_t  state_q, state_d;
  cfg_t    cfg_q, cfg_step, cfg_d;
  result_t res_q, res_d;
  logic    res_valid_q, res_valid_d;
  logic    in_fire, cfg_fire;

  cpuet_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .operation_i  (in_i.operation),
    .exc_code_i   (in_i.exc_code),
    .current_pc_i (in_i.current_pc),
    .delay_slot_i (in_i.delay_slot),
    .cpu_active_i (in_i.cpu_active),
    .state_o      (state_d),
    .cfg_o        (cfg_step),
    .result_o     (res_d)
  );

  assign in_i.ready  = !res_valid_q || res_o.ready;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = in_fire ? cfg_step : cfg_q;
    if (cfg_fire) begin
      case (cfg_i.index)
        CFG_TIMER_COMPARE: cfg_d.timer_compare = cfg_i.data;
        CFG_WIRED_LIMIT:   cfg_d.wired_limit   = cfg_i.data[RandW-1:0];
        CFG_BOOT_VECTORS:  cfg_d.boot_vectors  = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign res_valid_d = in_fire || (res_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      cfg_q       <= CFG_RESET;
      res_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      cfg_q       <= cfg_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.redirect          = res_q.redirect;
  assign res_o.target_pc         = res_q.target_pc;
  assign res_o.taken_code        = res_q.taken_code;
  assign res_o.saved_pc          = res_q.saved_pc;
  assign res_o.branch_delay_flag = res_q.branch_delay_flag;
  assign res_o.exception_level   = res_q.exception_level;
  assign res_o.count_value       = res_q.count_value;
  assign res_o.random_value      = res_q.random_value;
  assign res_o.timer_pending     = res_q.timer_pending;
  assign res_o.reset_kind        = res_q.reset_kind;

  a_taken_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_d.redirect |=> state_q.pending == CODE_NONE)
    else $error("pending code not cleared after a taken exception");

  a_raise_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op_e'(in_i.operation) == OP_RAISE) |=> $stable(state_q.count))
    else $error("raise transaction changed the cycle counter");

  a_result_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> res_valid_q && res_q.count_value == state_q.count)
    else $error("result missing or out of step with state");

  a_redirect_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.redirect |-> res_q.taken_code != CODE_NONE)
    else $error("redirect without a taken exception code");

endmodule

/* sv/cpuet_step.sv */
// next-state and result logic for one raise or step transaction
module cpuet_step (
  input  cpuet_pkg::state_t             state_i,
  input  cpuet_pkg::cfg_t               cfg_i,
  input  logic                          operation_i,
  input  logic [cpuet_pkg::CodeW-1:0]   exc_code_i,
  input  logic [cpuet_pkg::WordW-1:0]   current_pc_i,
  input  logic                          delay_slot_i,
  input  logic                          cpu_active_i,
  output cpuet_pkg::state_t             state_o,
  output cpuet_pkg::cfg_t               cfg_o,
  output cpuet_pkg::result_t            result_o
);
  import cpuet_pkg::*;

  logic [RandW-1:0] rand_dec;
  logic [WordW-1:0] pc_saved;

  assign pc_saved = delay_slot_i ? (current_pc_i - PC_STEP) : current_pc_i;

  always_comb begin
    state_o  = state_i;
    cfg_o    = cfg_i;
    rand_dec = '0;
    result_o = '{redirect: 1'b0, target_pc: '0, taken_code: CODE_NONE, saved_pc: '0,
                 branch_delay_flag: 1'b0, exception_level: 1'b0, count_value: '0,
                 random_value: '0, timer_pending: 1'b0, reset_kind: RK_NONE};
    if (op_e'(operation_i) == OP_RAISE) begin
      if (prio_of(exc_code_i) > prio_of(state_i.pending)) begin
        state_o.pending = exc_code_i;
      end
    end else begin
      state_o.count = state_i.count + 1'b1;
      if (cpu_active_i) begin
        if (state_i.pending != CODE_NONE) begin
          result_o.redirect   = 1'b1;
          result_o.taken_code = state_i.pending;
          if (!state_i.pending[CodeW-1]) begin
            state_o.cause = state_i.pending[4:0];
          end
          state_o.exl = 1'b1;
          case (state_i.pending)
            CODE_COLD: begin
              state_o             = STATE_RESET;
              cfg_o               = CFG_RESET;
              result_o.reset_kind = RK_COLD;
              result_o.target_pc  = VEC_RESET;
            end
            CODE_SOFT, CODE_NMI: begin
              result_o.reset_kind = (state_i.pending == CODE_SOFT) ? RK_SOFT : RK_NMI;
              state_o.error_epc   = current_pc_i;
              result_o.saved_pc   = current_pc_i;
              result_o.target_pc  = VEC_RESET;
            end
            default: begin
              result_o.saved_pc = pc_saved;
              state_o.bd        = delay_slot_i;
              state_o.epc       = pc_saved;
              if (state_i.pending == CODE_TLBL || state_i.pending == CODE_TLBS) begin
                result_o.target_pc = cfg_i.boot_vectors ? VEC_TLB_BOOT : VEC_TLB_NORM;
              end else begin
                result_o.target_pc = cfg_i.boot_vectors ? VEC_GEN_BOOT : VEC_GEN_NORM;
              end
            end
          endcase
          state_o.pending = CODE_NONE;
        end
        rand_dec       = state_o.random - 1'b1;
        state_o.random = (rand_dec < cfg_o.wired_limit) ? RAND_TOP : rand_dec;
      end
      if (state_o.count == cfg_o.timer_compare) begin
        state_o.timer = 1'b1;
      end
    end
    result_o.branch_delay_flag = state_o.bd;
    result_o.exception_level   = state_o.exl;
    result_o.count_value       = state_o.count;
    result_o.random_value      = state_o.random;
    result_o.timer_pending     = state_o.timer;
  end

endmodule

/* tb/sv/cpu_exception_and_timer_unit_test.sv */
// testbench of the cpu exception and timer unit: directed and random transactions checked against predictions
module cpu_exception_and_timer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cpuet_pkg::*;

  localparam logic [CodeW-1:0] EXC_INT   = 6'd0;
  localparam logic [CodeW-1:0] EXC_ADES  = 6'd5;
  localparam logic [CodeW-1:0] EXC_DBE   = 6'd7;
  localparam logic [CodeW-1:0] EXC_RI    = 6'd10;
  localparam logic [CodeW-1:0] EXC_VCEI  = 6'd14;
  localparam logic [CodeW-1:0] EXC_WTCH  = 6'd23;
  localparam logic [CodeW-1:0] EXC_TOP   = 6'd63;
  localparam int unsigned      PHASES    = 8;
  localparam int unsigned      PHASE_LEN = 125;

  class exc_timer_scoreboard;
    logic [WordW-1:0] cmp_reg;
    logic [RandW-1:0] wired_reg;
    logic             boot_reg;
    logic [CodeW-1:0] waiting_code;
    logic [WordW-1:0] cycles;
    logic [RandW-1:0] rnd_idx;
    logic             tmr_flag;
    logic             exl;
    logic [4:0]       cause;
    logic             bd;
    logic [WordW-1:0] epc;
    logic [WordW-1:0] err_epc;
    byte unsigned     rank_tbl[64];
    result_t          due_results[$];
    int unsigned      errors;

    function new();
      // codes from lowest to highest priority
      byte unsigned order[19] = '{0, 7, 23, 1, 2, 4, 15, 12, 13, 10, 11, 9, 8, 6, 3, 5,
                                  34, 33, 32};
      foreach (rank_tbl[i]) rank_tbl[i] = 0;
      foreach (order[i]) rank_tbl[order[i]] = 8'(i + 1);
      cold_defaults();
      waiting_code = CODE_NONE;
      errors = 0;
    endfunction

    function void cold_defaults();
      cmp_reg = '0;
      wired_reg = '0;
      boot_reg = 1'b1;
      cycles = '0;
      rnd_idx = RAND_TOP;
      tmr_flag = 1'b0;
      exl = 1'b0;
      cause = '0;
      bd = 1'b0;
      epc = '0;
      err_epc = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
      case (idx)
        CFG_TIMER_COMPARE: cmp_reg = data;
        CFG_WIRED_LIMIT:   wired_reg = data[RandW-1:0];
        CFG_BOOT_VECTORS:  boot_reg = data[0];
        default: ;
      endcase
    endfunction

    function void note_item(op_e op, logic [CodeW-1:0] code, logic [WordW-1:0] pc,
                            logic ds, logic act);
      result_t r;
      r = '0;
      r.taken_code = CODE_NONE;
      r.reset_kind = RK_NONE;
      if (op == OP_RAISE) begin
        if (rank_tbl[code] > rank_tbl[waiting_code]) waiting_code = code;
      end else begin
        cycles = cycles + 1;
        if (act) begin
          if (waiting_code != CODE_NONE) begin
            r.redirect = 1'b1;
            r.taken_code = waiting_code;
            if (waiting_code < CODE_COLD) cause = waiting_code[4:0];
            exl = 1'b1;
            if (waiting_code == CODE_COLD) begin
              r.reset_kind = RK_COLD;
              cold_defaults();
              r.target_pc = VEC_RESET;
            end else if (waiting_code == CODE_SOFT || waiting_code == CODE_NMI) begin
              r.reset_kind = (waiting_code == CODE_SOFT) ? RK_SOFT : RK_NMI;
              err_epc = pc;
              r.saved_pc = pc;
              r.target_pc = VEC_RESET;
            end else begin
              r.saved_pc = ds ? pc - PC_STEP : pc;
              bd = ds;
              epc = r.saved_pc;
              if (waiting_code == CODE_TLBL || waiting_code == CODE_TLBS) begin
                r.target_pc = boot_reg ? VEC_TLB_BOOT : VEC_TLB_NORM;
              end else begin
                r.target_pc = boot_reg ? VEC_GEN_BOOT : VEC_GEN_NORM;
              end
            end
            waiting_code = CODE_NONE;
          end
          rnd_idx = rnd_idx - 1'b1;
          if (rnd_idx < wired_reg) rnd_idx = RAND_TOP;
        end
        if (cycles == cmp_reg) tmr_flag = 1'b1;
      end
      r.branch_delay_flag = bd;
      r.exception_level = exl;
      r.count_value = cycles;
      r.random_value = rnd_idx;
      r.timer_pending = tmr_flag;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result transaction with none expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("redirect", want.redirect, got.redirect);
      compare_field("target_pc", want.target_pc, got.target_pc);
      compare_field("taken_code", want.taken_code, got.taken_code);
      compare_field("saved_pc", want.saved_pc, got.saved_pc);
      compare_field("branch_delay_flag", want.branch_delay_flag, got.branch_delay_flag);
      compare_field("exception_level", want.exception_level, got.exception_level);
      compare_field("count_value", want.count_value, got.count_value);
      compare_field("random_value", want.random_value, got.random_value);
      compare_field("timer_pending", want.timer_pending, got.timer_pending);
      compare_field("reset_kind", want.reset_kind, got.reset_kind);
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm = 1'b0;
  bit   gappy = 1'b1;

  exc_timer_scoreboard sb = new();

  cpuet_in_if  in_ch ();
  cpuet_res_if res_ch ();
  cpuet_cfg_if cfg_ch ();

  cpu_exception_and_timer_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always #6ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got.redirect = res_ch.redirect;
        got.target_pc = res_ch.target_pc;
        got.taken_code = res_ch.taken_code;
        got.saved_pc = res_ch.saved_pc;
        got.branch_delay_flag = res_ch.branch_delay_flag;
        got.exception_level = res_ch.exception_level;
        got.count_value = res_ch.count_value;
        got.random_value = res_ch.random_value;
        got.timer_pending = res_ch.timer_pending;
        got.reset_kind = reset_kind_e'(res_ch.reset_kind);
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item(op_e'(in_ch.operation), in_ch.exc_code, in_ch.current_pc,
                     in_ch.delay_slot, in_ch.cpu_active);
      end
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // result side back-pressure in random stretches
  initial begin
    int unsigned stall;
    int unsigned stretch;
    bit          noisy;
    stall = 0;
    stretch = 0;
    noisy = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        stretch = $urandom_range(20, 80);
        noisy = ($urandom_range(0, 2) != 0);
      end
      stretch--;
      if (!calm && noisy && stall == 0 && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4);
      end
      if (!calm && stall > 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input op_e op, input logic [CodeW-1:0] code,
                           input logic [WordW-1:0] pc, input logic ds, input logic act);
    int unsigned gap;
    gap = (!calm && gappy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.exc_code <= code;
    in_ch.current_pc <= pc;
    in_ch.delay_slot <= ds;
    in_ch.cpu_active <= act;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic raise(input logic [CodeW-1:0] code);
    send_item(OP_RAISE, code, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic step(input logic [WordW-1:0] pc, input logic ds, input logic act);
    send_item(OP_STEP, 6'($urandom_range(0, 63)), pc, ds, act);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [WordW-1:0] cmp, input logic [RandW-1:0] wired,
                          input logic boot);
    write_reg(CFG_TIMER_COMPARE, cmp);
    write_reg(CFG_WIRED_LIMIT, {{(WordW-RandW){1'b0}}, wired});
    write_reg(CFG_BOOT_VECTORS, {{(WordW-1){1'b0}}, boot});
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) raise(CODE_COLD);
      else if (sel < 7) raise(CODE_SOFT);
      else if (sel < 11) raise(CODE_NMI);
      else if (sel < 87) raise(6'($urandom_range(0, 31)));
      else raise(6'($urandom_range(35, 63)));
    end else begin
      step($urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    logic [WordW-1:0] cmp;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_RAISE;
    in_ch.exc_code = '0;
    in_ch.current_pc = '0;
    in_ch.delay_slot = 1'b0;
    in_ch.cpu_active = 1'b0;
    res_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TIMER_COMPARE;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    step(32'h0000_0040, 1'b0, 1'b0);
    raise(EXC_INT);
    raise(EXC_VCEI);
    step(32'h0000_1000, 1'b0, 1'b1);
    raise(CODE_TLBL);
    step(32'h0000_0000, 1'b1, 1'b1);
    raise(CODE_TLBS);
    raise(EXC_ADES);
    raise(EXC_RI);
    step(32'hFFFF_FFFF, 1'b1, 1'b1);
    raise(EXC_TOP);
    step(32'h8000_0000, 1'b0, 1'b1);
    raise(CODE_SOFT);
    raise(EXC_WTCH);
    step(32'hFFFF_FFFF, 1'b1, 1'b1);
    raise(CODE_NMI);
    step(32'h0000_2000, 1'b0, 1'b0);
    step(32'h1234_5678, 1'b1, 1'b1);
    raise(CODE_COLD);
    raise(CODE_NMI);
    step(32'hDEAD_BEEC, 1'b1, 1'b1);
    settle();
    set_regs(32'hFFFF_FFFF, 5'd31, 1'b0);
    raise(CODE_TLBS);
    step(32'h0000_0004, 1'b1, 1'b1);
    raise(EXC_DBE);
    step(32'h7FFF_FFF0, 1'b0, 1'b1);
    settle();

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: set_regs(32'hFFFF_FFFF, 5'd31, 1'b1);
        1: set_regs(sb.cycles + $urandom_range(1, 30), 5'd0, 1'b0);
        default: begin
          case ($urandom_range(0, 2))
            0: cmp = sb.cycles + $urandom_range(1, 100);
            1: cmp = $urandom;
            default: cmp = '0;
          endcase
          set_regs(cmp, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        end
      endcase
      calm = (p == PHASES - 1);
      gappy = ($urandom_range(0, 3) != 0);
      repeat (PHASE_LEN) random_item();
      settle();
    end

    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
